// ----- hdl/lru_frame_tracker_macros.svh -----
// Assertion helpers used by the recency stack module.
`ifndef LRU_FRAME_TRACKER_MACROS_SVH
`define LRU_FRAME_TRACKER_MACROS_SVH

// Checked on every clock edge outside reset.
`define LFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LFT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/lft_pkg.sv -----
package lft_pkg;

    localparam int FRAME_W            = 6;
    localparam int FRAME_IDS          = 64;
    localparam int CFG_W              = 7;
    localparam int NUM_FRAMES_DEFAULT = 64;
    localparam logic [CFG_W-1:0] FRAMES_RESET = 7'd64;
    localparam int IN_TDATA_W         = 8;
    localparam int OUT_TDATA_W        = 16;

    typedef struct packed {
        logic               index_error;
        logic               tracker_empty;
        logic [FRAME_W-1:0] victim_frame;
        logic [FRAME_W-1:0] dropped_frame;
        logic               dropped_valid;
        logic               was_resident;
    } t_result;

endpackage

// ----- hdl/lft_recency_stack.sv -----
`include "lru_frame_tracker_macros.svh"

module lft_recency_stack
    import lft_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_step,
    input  logic [FRAME_W-1:0] i_frame,
    input  logic [CFG_W-1:0]   i_lim,
    output t_result            o_result
);

    localparam int PW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);

    logic [FRAME_W-1:0]   r_stack [NUM_FRAMES];
    logic [FRAME_W-1:0]   n_stack [NUM_FRAMES];
    logic [FRAME_IDS-1:0] r_resident;
    logic [FRAME_IDS-1:0] n_resident;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;

    logic [NUM_FRAMES-1:0] match;
    logic [NUM_FRAMES-1:0] shift_en;
    logic                  hit;
    logic                  err;
    logic                  full;
    logic [FRAME_W-1:0]    drop_frame;
    logic [PW-1:0]         last_idx;
    logic [PW-1:0]         victim_idx;

    always_comb begin
        logic [NUM_FRAMES-1:0] low_mask;
        low_mask = '0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            match[i] = (r_stack[i] == i_frame);
        end
        for (int i = 0; i < NUM_FRAMES; i++) begin
            low_mask    = (NUM_FRAMES'(1) << i) - NUM_FRAMES'(1);
            shift_en[i] = ~(|(match & low_mask));
        end
    end

    always_comb begin
        hit        = r_resident[i_frame];
        err        = ({1'b0, i_frame} >= i_lim);
        full       = (32'(r_count) >= 32'(i_lim)) && (r_count != '0);
        last_idx   = PW'(r_count - CW'(1));
        drop_frame = r_stack[last_idx];

        n_stack    = r_stack;
        n_resident = r_resident;
        n_count    = r_count;

        if (!err) begin
            if (hit) begin
                for (int i = 1; i < NUM_FRAMES; i++) begin
                    if (shift_en[i]) begin
                        n_stack[i] = r_stack[i-1];
                    end
                end
                n_stack[0] = i_frame;
            end else begin
                if (full) begin
                    n_resident[drop_frame] = 1'b0;
                    n_count                = r_count - CW'(1);
                end
                for (int i = 1; i < NUM_FRAMES; i++) begin
                    n_stack[i] = r_stack[i-1];
                end
                n_stack[0]          = i_frame;
                n_resident[i_frame] = 1'b1;
                if (32'(n_count) < NUM_FRAMES) begin
                    n_count = n_count + CW'(1);
                end
            end
        end
    end

    always_comb begin
        victim_idx             = PW'(n_count - CW'(1));
        o_result.was_resident  = hit && !err;
        o_result.dropped_valid = !err && !hit && full;
        o_result.dropped_frame = (!err && !hit && full) ? drop_frame : '0;
        o_result.index_error   = err;
        if (n_count == '0) begin
            o_result.victim_frame  = '0;
            o_result.tracker_empty = 1'b1;
        end else begin
            o_result.victim_frame  = n_stack[victim_idx];
            o_result.tracker_empty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_stack <= n_stack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resident <= '0;
            r_count    <= '0;
        end else if (i_clear) begin
            r_resident <= '0;
            r_count    <= '0;
        end else if (i_step) begin
            r_resident <= n_resident;
            r_count    <= n_count;
        end
    end

    `LFT_ASSERT(a_count_matches_resident, $countones(r_resident) == 32'(r_count), "tracked count differs from resident flags")
    `LFT_ASSERT(a_count_in_range, 32'(r_count) <= NUM_FRAMES, "tracked count above stack depth")
    `LFT_ASSERT(a_hit_keeps_count, (i_step && !i_clear && hit && !err) |=> $stable(r_count), "hit changed tracked count")
    `LFT_ASSERT(a_clear_empties, i_clear |=> (r_count == '0 && r_resident == '0), "clear left frames tracked")

endmodule

// ----- hdl/lft_result_reg.sv -----
module lft_result_reg
    import lft_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hdl/lru_frame_tracker.sv -----
// Exact LRU tracker over up to NUM_FRAMES physical frames, kept as a recency
// stack. Each input beat references one frame; each output beat reports whether
// the frame was already tracked, the frame dropped to make room (if any), the
// least recently used frame after the update and an empty flag. Indexes at or
// above the configured frame count are flagged and leave the state untouched.
// One reference is accepted every cycle unless the result side stalls; its result
// goes through an input register that feeds the stack update, whose outcome
// lands in the output register. Writing the frame count clears the tracker; a
// count of zero acts as one and a count above NUM_FRAMES acts as NUM_FRAMES.
module lru_frame_tracker
    import lft_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,      // frames_in_use
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // frame_index, zero pad
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata   // was_resident, dropped_valid,
                                                    // dropped_frame, victim_frame,
                                                    // tracker_empty, index_error
);

    logic [CFG_W-1:0]   r_cfg;
    logic               r_in_valid;
    logic [FRAME_W-1:0] r_in_frame;
    logic [CFG_W-1:0]   lim;
    logic               advance;
    logic               cfg_write;
    logic               out_valid;
    t_result            step_result;
    t_result            out_result;

    assign cfg_write       = i_cfg_valid;
    assign o_cfg_ready     = 1'b1;
    assign advance         = r_in_valid && (!out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_comb begin
        lim = r_cfg;
        if (r_cfg == '0) begin
            lim = CFG_W'(1);
        end else if (32'(r_cfg) > NUM_FRAMES) begin
            lim = CFG_W'(NUM_FRAMES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= FRAMES_RESET;
        end else if (cfg_write) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_frame <= i_s_axis_tdata[FRAME_W-1:0];
        end
    end

    lft_recency_stack #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_write),
        .i_step  (advance),
        .i_frame (r_in_frame),
        .i_lim   (lim),
        .o_result(step_result)
    );

    lft_result_reg u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_result(step_result),
        .i_ready (i_m_axis_tready),
        .o_valid (out_valid),
        .o_result(out_result)
    );

    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = {out_result.index_error, out_result.tracker_empty,
                              out_result.victim_frame, out_result.dropped_frame,
                              out_result.dropped_valid, out_result.was_resident};

endmodule

// ----- dv/lru_frame_tracker_checker.sv -----
module lru_frame_tracker_checker
    import lft_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_ref_valid,
    input  logic                   i_ref_ready,
    input  logic [IN_TDATA_W-1:0]  i_ref_data,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [OUT_TDATA_W-1:0] i_res_data,
    output int                     o_outstanding,
    output int                     o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [FRAME_W-1:0] lru_order [NUM_FRAMES];
    bit                 frame_tracked [FRAME_IDS];
    int                 tracked_frames;
    logic [CFG_W-1:0]   frames_cfg;
    t_result            expected_results [$];
    int                 mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void clear_tracker();
        tracked_frames = 0;
        foreach (frame_tracked[i]) begin
            frame_tracked[i] = 1'b0;
        end
    endfunction

    function automatic void shift_toward_lru(input int top);
        for (int i = top; i > 0; i--) begin
            if (i < NUM_FRAMES) begin
                lru_order[i] = lru_order[i-1];
            end
        end
    endfunction

    function automatic t_result predict_reference(input logic [FRAME_W-1:0] frame);
        int      limit;
        int      pos;
        t_result res;
        if (frames_cfg == '0) begin
            limit = 1;
        end else if (frames_cfg > NUM_FRAMES) begin
            limit = NUM_FRAMES;
        end else begin
            limit = int'(frames_cfg);
        end
        res = '0;
        if (frame >= limit || frame >= NUM_FRAMES) begin
            res.index_error = 1'b1;
        end else if (frame_tracked[frame]) begin
            res.was_resident = 1'b1;
            pos = 0;
            while (pos < tracked_frames && lru_order[pos] != frame) begin
                pos++;
            end
            if (pos < tracked_frames) begin
                shift_toward_lru(pos);
                lru_order[0] = frame;
            end
        end else begin
            if (tracked_frames >= limit && tracked_frames > 0) begin
                res.dropped_valid = 1'b1;
                res.dropped_frame = lru_order[tracked_frames-1];
                frame_tracked[res.dropped_frame] = 1'b0;
                tracked_frames--;
            end
            shift_toward_lru(tracked_frames);
            lru_order[0] = frame;
            frame_tracked[frame] = 1'b1;
            if (tracked_frames < NUM_FRAMES) begin
                tracked_frames++;
            end
        end
        if (tracked_frames == 0) begin
            res.tracker_empty = 1'b1;
        end else begin
            res.victim_frame = lru_order[tracked_frames-1];
        end
        return res;
    endfunction

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result beat with nothing expected", got, '0);
            return;
        end
        want = expected_results.pop_front();
        if (got.was_resident !== want.was_resident) begin
            report_mismatch("was_resident", 16'(got.was_resident), 16'(want.was_resident));
        end
        if (got.dropped_valid !== want.dropped_valid) begin
            report_mismatch("dropped_valid", 16'(got.dropped_valid),
                            16'(want.dropped_valid));
        end
        if (got.dropped_frame !== want.dropped_frame) begin
            report_mismatch("dropped_frame", 16'(got.dropped_frame),
                            16'(want.dropped_frame));
        end
        if (got.victim_frame !== want.victim_frame) begin
            report_mismatch("victim_frame", 16'(got.victim_frame), 16'(want.victim_frame));
        end
        if (got.tracker_empty !== want.tracker_empty) begin
            report_mismatch("tracker_empty", 16'(got.tracker_empty),
                            16'(want.tracker_empty));
        end
        if (got.index_error !== want.index_error) begin
            report_mismatch("index_error", 16'(got.index_error), 16'(want.index_error));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frames_cfg = FRAMES_RESET;
            clear_tracker();
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                check_result(t_result'(i_res_data));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                frames_cfg = i_cfg_data;
                clear_tracker();
            end
            if (i_ref_valid && i_ref_ready) begin
                expected_results.push_back(predict_reference(i_ref_data[FRAME_W-1:0]));
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

// ----- dv/lru_frame_tracker_tb.sv -----
module lru_frame_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lft_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int LONG_HOLD      = 60;
    localparam int PHASES         = 8;
    localparam int RANDOM_REFS    = 1000;
    localparam int PRESSURE_REFS  = 40;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   cfg_ready;
    logic                   ref_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  ref_data  = '0;
    logic                   ref_ready;
    logic                   res_valid;
    logic                   res_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] res_data;
    int                     outstanding;
    int                     mismatches;

    int                     idle_pct     = 0;
    int                     stall_pct    = 0;
    int                     hold_seq     = 0;
    int                     quiet_cycles = 0;
    int                     frames_limit = int'(FRAMES_RESET);
    logic [FRAME_W-1:0]     recent_refs [4];
    logic [CFG_W-1:0]       phase_frames [PHASES];

    lru_frame_tracker dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (ref_valid),
        .o_s_axis_tready (ref_ready),
        .i_s_axis_tdata  (ref_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data)
    );

    lru_frame_tracker_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_ref_valid   (ref_valid),
        .i_ref_ready   (ref_ready),
        .i_ref_data    (ref_data),
        .i_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .i_res_data    (res_data),
        .o_outstanding (outstanding),
        .o_mismatches  (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                res_ready <= 1'b0;
                hold_left--;
            end else begin
                res_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cfg_valid && cfg_ready) || (ref_valid && ref_ready)
                || (res_valid && res_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_ref(input logic [FRAME_W-1:0] frame);
        while ($urandom_range(99) < idle_pct) begin
            ref_valid <= 1'b0;
            @(posedge clk);
        end
        ref_valid <= 1'b1;
        ref_data  <= IN_TDATA_W'(frame);
        do @(posedge clk); while (!ref_ready);
        recent_refs[$urandom_range(3)] = frame;
    endtask

    task automatic wait_drained();
        ref_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value == '0) begin
            frames_limit = 1;
        end else if (value > FRAME_IDS) begin
            frames_limit = FRAME_IDS;
        end else begin
            frames_limit = int'(value);
        end
        foreach (recent_refs[i]) begin
            recent_refs[i] = '0;
        end
    endtask

    function automatic logic [FRAME_W-1:0] pick_frame();
        int r;
        r = $urandom_range(99);
        if (frames_limit < FRAME_IDS && r < 10) begin
            return FRAME_W'($urandom_range(FRAME_IDS - 1, frames_limit));
        end
        if (r < 35) begin
            return recent_refs[$urandom_range(3)];
        end
        return FRAME_W'($urandom_range(frames_limit - 1));
    endfunction

    task automatic run_random(input int count);
        int                 in_range;
        logic [FRAME_W-1:0] frame;
        in_range = 0;
        while (in_range < count) begin
            frame = pick_frame();
            send_ref(frame);
            if (frame < frames_limit) begin
                in_range++;
            end
        end
    endtask

    initial begin
        foreach (recent_refs[i]) begin
            recent_refs[i] = '0;
        end
        phase_frames = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd2, 7'd5, 7'd33, 7'd63};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        send_ref(6'd0);
        send_ref(6'd63);
        send_ref(6'd0);
        send_ref(6'd0);
        send_ref(6'd63);

        write_frames(7'd0);
        send_ref(6'd1);
        send_ref(6'd0);
        send_ref(6'd0);
        send_ref(6'd63);

        write_frames(7'd127);
        send_ref(6'd63);
        send_ref(6'd62);
        send_ref(6'd0);
        send_ref(6'd63);
        send_ref(6'd42);
        send_ref(6'd21);

        write_frames(7'd3);
        send_ref(6'd2);
        send_ref(6'd1);
        send_ref(6'd0);
        send_ref(6'd2);
        send_ref(6'd3);
        send_ref(6'd7);

        for (int p = 0; p < PHASES; p++) begin
            write_frames(phase_frames[p]);
            case (p % 4)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct = 49;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 49;
                end
                default: begin
                    idle_pct = 16;
                    stall_pct <= 16;
                end
            endcase
            run_random(RANDOM_REFS / PHASES);
            if (p == 0) begin
                // Hold the result side off while references keep coming, so the
                // tracker backs up, then let everything in flight come out.
                hold_seq <= hold_seq + 1;
                run_random(PRESSURE_REFS);
                wait_drained();
                run_random(PRESSURE_REFS);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
